// ----- rtl/dpcmv_pkg.sv -----
// Package for the vertical-prediction DPCM encoder.
// Holds the register map, field widths, reset values and shared struct types.
// No dependencies; every other file of the block refers to it, by scoped names or by import.
package dpcmv_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 4096;

  localparam int unsigned PixelW       = 8;
  localparam int unsigned LineWidthW   = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned PaddrW       = 4;
  localparam int unsigned RegIdxW      = 2;

  localparam logic [RegIdxW-1:0] RegLineWidth   = 2'd0;
  localparam logic [RegIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic [RegIdxW-1:0] RegQuantMode   = 2'd2;

  localparam logic [LineWidthW-1:0]   LineWidthRst   = 11'd1024;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 13'd1;

  localparam logic ModeByte   = 1'b0;
  localparam logic ModeNibble = 1'b1;

  localparam logic [PixelW-1:0] PredFirstRow = 8'd128;
  localparam logic [PixelW:0]   DiffOffset   = 9'd255;

  typedef struct packed {
    logic [LineWidthW-1:0]   line_width;
    logic [FrameHeightW-1:0] frame_height;
    logic                    quant_mode;
  } cfg_t;

  typedef struct packed {
    logic first_row;
    logic last;
    logic quant_mode;
  } item_ctl_t;

endpackage

// ----- rtl/dpcmv_if.sv -----
// Stream interfaces of the DPCM encoder: pixel input and code output channels.
// Depends on dpcmv_pkg for the field widths.
interface dpcmv_pix_if;
  logic                         valid;
  logic                         ready;
  logic [dpcmv_pkg::PixelW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface dpcmv_code_if;
  logic                         valid;
  logic                         ready;
  logic [dpcmv_pkg::PixelW-1:0] code_byte;
  logic                         code_valid;
  logic [dpcmv_pkg::PixelW-1:0] recon;
  logic                         frame_last;

  modport source (output valid, output code_byte, output code_valid, output recon,
                  output frame_last, input ready);
  modport sink   (input valid, input code_byte, input code_valid, input recon,
                  input frame_last, output ready);
endinterface

// ----- rtl/dpcmv_cfg_regs.sv -----
// APB-style configuration registers of the DPCM encoder.
// Depends on dpcmv_pkg for the register map and reset values.
module dpcmv_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dpcmv_pkg::PaddrW-1:0]        paddr,
  input  logic [dpcmv_pkg::ApbDataW-1:0]      pwdata,
  output logic [dpcmv_pkg::ApbDataW-1:0]      prdata,
  output logic                                pready,
  output dpcmv_pkg::cfg_t                     cfg_o
);

  dpcmv_pkg::cfg_t                   cfg_q;
  logic [dpcmv_pkg::RegIdxW-1:0]     reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[dpcmv_pkg::PaddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width   <= dpcmv_pkg::LineWidthRst;
      cfg_q.frame_height <= dpcmv_pkg::FrameHeightRst;
      cfg_q.quant_mode   <= dpcmv_pkg::ModeByte;
    end else if (wr_en) begin
      case (reg_idx)
        dpcmv_pkg::RegLineWidth: begin
          cfg_q.line_width <= pwdata[dpcmv_pkg::LineWidthW-1:0];
        end
        dpcmv_pkg::RegFrameHeight: begin
          cfg_q.frame_height <= pwdata[dpcmv_pkg::FrameHeightW-1:0];
        end
        dpcmv_pkg::RegQuantMode: begin
          cfg_q.quant_mode <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      dpcmv_pkg::RegLineWidth: begin
        prdata = dpcmv_pkg::ApbDataW'(cfg_q.line_width);
      end
      dpcmv_pkg::RegFrameHeight: begin
        prdata = dpcmv_pkg::ApbDataW'(cfg_q.frame_height);
      end
      dpcmv_pkg::RegQuantMode: begin
        prdata = dpcmv_pkg::ApbDataW'(cfg_q.quant_mode);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// ----- rtl/dpcmv_line_store.sv -----
// One-line store of reconstructed pixels, one read and one write port.
// Read data is registered; a write to the address being read is forwarded.
// Depends on dpcmv_pkg for the pixel width.
module dpcmv_line_store #(
  parameter int unsigned DEPTH = dpcmv_pkg::MaxWidthDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [dpcmv_pkg::PixelW-1:0] wr_data_i,
  output logic [dpcmv_pkg::PixelW-1:0] rd_data_o
);

  logic [dpcmv_pkg::PixelW-1:0] mem_q [DEPTH];
  logic [dpcmv_pkg::PixelW-1:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

endmodule

// ----- rtl/dpcmv_ctrl.sv -----
// Input side of the DPCM encoder: column and row counters, line store read
// and the input register that feeds the quantiser.
// Depends on dpcmv_pkg and the pixel stream interface.
module dpcmv_ctrl #(
  parameter int unsigned MAX_WIDTH  = dpcmv_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = dpcmv_pkg::MaxHeightDef,
  parameter int unsigned COL_W      = $clog2(MAX_WIDTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dpcmv_pkg::cfg_t              cfg_i,
  dpcmv_pix_if.sink                    pix_i,
  input  logic                         out_free_i,
  output logic                         adv_o,
  output logic [dpcmv_pkg::PixelW-1:0] a_pixel_o,
  output logic [COL_W-1:0]             a_col_o,
  output dpcmv_pkg::item_ctl_t         a_ctl_o,
  output logic                         rd_en_o,
  output logic [COL_W-1:0]             rd_addr_o
);

  localparam int unsigned ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WCMP_W = ($clog2(MAX_WIDTH + 1) > dpcmv_pkg::LineWidthW) ?
                                   $clog2(MAX_WIDTH + 1) : dpcmv_pkg::LineWidthW;
  localparam int unsigned HCMP_W = ($clog2(MAX_HEIGHT + 1) > dpcmv_pkg::FrameHeightW) ?
                                   $clog2(MAX_HEIGHT + 1) : dpcmv_pkg::FrameHeightW;
  localparam logic [WCMP_W-1:0] MaxW = WCMP_W'(MAX_WIDTH);
  localparam logic [HCMP_W-1:0] MaxH = HCMP_W'(MAX_HEIGHT);

  logic [COL_W-1:0]             col_q, col_d;
  logic [ROW_W-1:0]             row_q, row_d;
  logic                         a_valid_q;
  logic [dpcmv_pkg::PixelW-1:0] a_pixel_q;
  logic [COL_W-1:0]             a_col_q;
  dpcmv_pkg::item_ctl_t         a_ctl_q;

  logic [WCMP_W-1:0] lw_ext, w_eff, col_inc;
  logic [HCMP_W-1:0] fh_ext, h_eff, row_inc;
  logic              accept, row_end, last, adv;

  assign lw_ext  = WCMP_W'(cfg_i.line_width);
  assign fh_ext  = HCMP_W'(cfg_i.frame_height);
  assign w_eff   = (lw_ext == '0) ? WCMP_W'(1) : ((lw_ext > MaxW) ? MaxW : lw_ext);
  assign h_eff   = (fh_ext == '0) ? HCMP_W'(1) : ((fh_ext > MaxH) ? MaxH : fh_ext);
  assign col_inc = WCMP_W'(col_q) + WCMP_W'(1);
  assign row_inc = HCMP_W'(row_q) + HCMP_W'(1);
  assign row_end = col_inc >= w_eff;
  assign last    = row_end && (row_inc >= h_eff);

  assign adv         = a_valid_q && out_free_i;
  assign pix_i.ready = !a_valid_q || out_free_i;
  assign accept      = pix_i.valid && pix_i.ready;

  assign adv_o     = adv;
  assign a_pixel_o = a_pixel_q;
  assign a_col_o   = a_col_q;
  assign a_ctl_o   = a_ctl_q;
  assign rd_en_o   = accept;
  assign rd_addr_o = col_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = last ? '0 : ROW_W'(row_inc);
      end else begin
        col_d = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (adv) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pixel_q          <= pix_i.pixel;
      a_col_q            <= col_q;
      a_ctl_q.first_row  <= (row_q == '0);
      a_ctl_q.last       <= last;
      a_ctl_q.quant_mode <= cfg_i.quant_mode;
    end
  end

endmodule

// ----- rtl/dpcmv_quant.sv -----
// Quantiser and code packer of the DPCM encoder with its output register.
// Computes code and clamped reconstruction, pairs nibble-mode 4-bit codes into bytes.
// Depends on dpcmv_pkg and the code stream interface.
module dpcmv_quant (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [dpcmv_pkg::PixelW-1:0] a_pixel_i,
  input  dpcmv_pkg::item_ctl_t         a_ctl_i,
  input  logic [dpcmv_pkg::PixelW-1:0] pred_above_i,
  output logic [dpcmv_pkg::PixelW-1:0] recon_o,
  output logic                         out_free_o,
  dpcmv_code_if.source                 code_o
);

  logic [dpcmv_pkg::PixelW-1:0] pred;
  logic [8:0]                   num;
  logic [8:0]                   qrec;
  logic [10:0]                  rsum;
  logic [dpcmv_pkg::PixelW-1:0] recon;
  logic [7:0]                   byte_d;
  logic                         byte_vld_d;
  logic [3:0]                   held_q, held_d;
  logic                         held_vld_q, held_vld_d;

  logic                         out_vld_q;
  logic [7:0]                   out_byte_q;
  logic                         out_cvld_q;
  logic [dpcmv_pkg::PixelW-1:0] out_recon_q;
  logic                         out_last_q;

  assign pred = a_ctl_i.first_row ? dpcmv_pkg::PredFirstRow : pred_above_i;
  assign num  = ({1'b0, a_pixel_i} + dpcmv_pkg::DiffOffset) - {1'b0, pred};
  assign qrec = (a_ctl_i.quant_mode == dpcmv_pkg::ModeNibble) ?
                {num[8:5], 5'b0} : {num[8:1], 1'b0};
  assign rsum = ({2'b0, qrec} + {3'b0, pred}) - 11'd255;

  always_comb begin
    if (rsum[10]) begin
      recon = '0;
    end else if (rsum[9:8] != 2'b00) begin
      recon = 8'hFF;
    end else begin
      recon = rsum[7:0];
    end
  end

  assign recon_o = recon;

  always_comb begin
    byte_d     = '0;
    byte_vld_d = 1'b0;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    if (a_ctl_i.quant_mode == dpcmv_pkg::ModeByte) begin
      byte_d     = num[8:1];
      byte_vld_d = 1'b1;
      held_d     = '0;
      held_vld_d = 1'b0;
    end else if (held_vld_q) begin
      byte_d     = {held_q, num[8:5]};
      byte_vld_d = 1'b1;
      held_d     = '0;
      held_vld_d = 1'b0;
    end else if (a_ctl_i.last) begin
      byte_d     = {num[8:5], 4'b0};
      byte_vld_d = 1'b1;
    end else begin
      held_d     = num[8:5];
      held_vld_d = 1'b1;
    end
    if (a_ctl_i.last) begin
      held_d     = '0;
      held_vld_d = 1'b0;
    end
  end

  assign out_free_o = !out_vld_q || code_o.ready;

  assign code_o.valid      = out_vld_q;
  assign code_o.code_byte  = out_byte_q;
  assign code_o.code_valid = out_cvld_q;
  assign code_o.recon      = out_recon_q;
  assign code_o.frame_last = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else begin
      if (adv_i) begin
        out_vld_q  <= 1'b1;
        held_q     <= held_d;
        held_vld_q <= held_vld_d;
      end else if (code_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_byte_q  <= byte_d;
      out_cvld_q  <= byte_vld_d;
      out_recon_q <= recon;
      out_last_q  <= a_ctl_i.last;
    end
  end

endmodule

// ----- rtl/dpcm_vertical_uniform_encoder.sv -----
// DPCM encoder with vertical prediction and a uniform quantiser, top level.
// Depends on dpcmv_pkg, the stream interfaces and the dpcmv_* submodules.
//
// Pixels arrive in raster order, one per transfer, and every pixel yields one
// result transfer carrying the code byte (with its own valid flag), the
// reconstructed pixel and a frame-last flag. The block takes one pixel per
// clock cycle while the output is not stalled. A result is offered from the
// output register: the input register holds the pixel while the line store
// (one read, one write port) returns the pixel above it, and the quantiser
// then loads the output register. A stalled output holds the pipeline, which
// keeps at most two pixels. The user writes configuration through the APB
// port only while no pixel is in flight; the block does not enforce it.
module dpcm_vertical_uniform_encoder #(
  parameter int unsigned MAX_WIDTH  = dpcmv_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = dpcmv_pkg::MaxHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dpcmv_pkg::PaddrW-1:0]   paddr,
  input  logic [dpcmv_pkg::ApbDataW-1:0] pwdata,
  output logic [dpcmv_pkg::ApbDataW-1:0] prdata,
  output logic                           pready,
  dpcmv_pix_if.sink                      pix_i,
  dpcmv_code_if.source                   code_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  dpcmv_pkg::cfg_t              cfg;
  dpcmv_pkg::item_ctl_t         a_ctl;
  logic                         adv;
  logic                         out_free;
  logic [dpcmv_pkg::PixelW-1:0] a_pixel;
  logic [COL_W-1:0]             a_col;
  logic                         rd_en;
  logic [COL_W-1:0]             rd_addr;
  logic [dpcmv_pkg::PixelW-1:0] pred_above;
  logic [dpcmv_pkg::PixelW-1:0] recon;

  dpcmv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dpcmv_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pix_i      (pix_i),
    .out_free_i (out_free),
    .adv_o      (adv),
    .a_pixel_o  (a_pixel),
    .a_col_o    (a_col),
    .a_ctl_o    (a_ctl),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  dpcmv_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (adv),
    .wr_addr_i (a_col),
    .wr_data_i (recon),
    .rd_data_o (pred_above)
  );

  dpcmv_quant u_quant (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .a_pixel_i    (a_pixel),
    .a_ctl_i      (a_ctl),
    .pred_above_i (pred_above),
    .recon_o      (recon),
    .out_free_o   (out_free),
    .code_o       (code_o)
  );

endmodule

// ----- test/dpcm_vertical_uniform_encoder_test.sv -----
// Self-checking testbench of the vertical-prediction DPCM encoder: a directed table, then
// random pixel streams under several idle and stall mixes, checked against a predictor.
// Depends on dpcmv_pkg, the stream interfaces and dpcm_vertical_uniform_encoder.
module dpcm_vertical_uniform_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dpcmv_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 5;
  localparam int MaxLine       = MaxWidthDef;
  localparam int MaxRows       = MaxHeightDef;
  localparam int PixelMax      = (1 << PixelW) - 1;
  localparam int WidthFieldMax = (1 << LineWidthW) - 1;
  localparam int RowsFieldMax  = (1 << FrameHeightW) - 1;
  localparam int ByteStep      = 2;
  localparam int NibbleStep    = 32;
  localparam int SettleCycles  = 4;
  localparam int IdleLimit     = 2000;
  localparam int LongHold      = 300;
  localparam int Phases        = 24;
  localparam int PhaseItems    = 45;
  localparam int PressurePhase = 8;
  localparam int DirRows       = 29;

  typedef struct packed {
    logic [PixelW-1:0] code_byte;
    logic              code_valid;
    logic [PixelW-1:0] recon;
    logic              frame_last;
  } code_res_t;

  typedef enum logic [1:0] {RowCfg, RowPixel, RowCheck} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [RegIdxW-1:0]      reg_idx;
    logic [FrameHeightW-1:0] value;
    logic [PixelW-1:0]       px;
    code_res_t               want;
  } dir_row_t;

  localparam code_res_t NoRes = '0;

  localparam dir_row_t DirTable [DirRows] = '{
    '{RowCfg,   RegLineWidth,   13'd3,    8'd0,   NoRes},
    '{RowCfg,   RegFrameHeight, 13'd2,    8'd0,   NoRes},
    '{RowCheck, '0,             '0,       8'd0,   '{8'd63,  1'b1, 8'd0,   1'b0}},
    '{RowCheck, '0,             '0,       8'd255, '{8'd191, 1'b1, 8'd255, 1'b0}},
    '{RowCheck, '0,             '0,       8'd128, '{8'd127, 1'b1, 8'd127, 1'b0}},
    '{RowCheck, '0,             '0,       8'd255, '{8'd255, 1'b1, 8'd255, 1'b0}},
    '{RowCheck, '0,             '0,       8'd0,   '{8'd0,   1'b1, 8'd0,   1'b0}},
    '{RowPixel, '0,             '0,       8'd200, NoRes},
    '{RowCfg,   RegQuantMode,   13'd1,    8'd0,   NoRes},
    '{RowCfg,   RegLineWidth,   13'd1,    8'd0,   NoRes},
    '{RowCfg,   RegFrameHeight, 13'd3,    8'd0,   NoRes},
    '{RowCheck, '0,             '0,       8'd255, '{8'h00,  1'b0, 8'd225, 1'b0}},
    '{RowCheck, '0,             '0,       8'd0,   '{8'hB0,  1'b1, 8'd0,   1'b0}},
    '{RowCheck, '0,             '0,       8'd255, '{8'hF0,  1'b1, 8'd225, 1'b1}},
    '{RowCfg,   RegLineWidth,   13'd0,    8'd0,   NoRes},
    '{RowCfg,   RegFrameHeight, 13'd0,    8'd0,   NoRes},
    '{RowCheck, '0,             '0,       8'd255, '{8'hB0,  1'b1, 8'd225, 1'b1}},
    '{RowCheck, '0,             '0,       8'd0,   '{8'h30,  1'b1, 8'd0,   1'b1}},
    '{RowCfg,   RegLineWidth,   13'd2047, 8'd0,   NoRes},
    '{RowCfg,   RegFrameHeight, 13'd8191, 8'd0,   NoRes},
    '{RowPixel, '0,             '0,       8'd17,  NoRes},
    '{RowPixel, '0,             '0,       8'd240, NoRes},
    '{RowPixel, '0,             '0,       8'd99,  NoRes},
    '{RowCfg,   RegQuantMode,   13'd0,    8'd0,   NoRes},
    '{RowCfg,   RegLineWidth,   13'd2,    8'd0,   NoRes},
    '{RowPixel, '0,             '0,       8'd5,   NoRes},
    '{RowCfg,   RegFrameHeight, 13'd1,    8'd0,   NoRes},
    '{RowPixel, '0,             '0,       8'd250, NoRes},
    '{RowPixel, '0,             '0,       8'd3,   NoRes}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  dpcmv_pix_if  pix ();
  dpcmv_code_if code ();

  dpcm_vertical_uniform_encoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix),
    .code_o  (code)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  logic [LineWidthW-1:0]   cfg_width = LineWidthRst;
  logic [FrameHeightW-1:0] cfg_height = FrameHeightRst;
  logic                    cfg_mode = ModeByte;
  logic [PixelW-1:0]       recon_line [MaxLine];
  int                      line_col = 0;
  int                      line_row = 0;
  int                      store_fill = 0;
  logic [3:0]              held_code = '0;
  bit                      held_valid = 1'b0;

  code_res_t pending_codes [$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  event      hold_go;
  bit        hold_active = 1'b0;
  int        quiet_cycles = 0;

  function automatic int clamp_size(input int v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic code_res_t encode_pixel(input logic [PixelW-1:0] px);
    int        w;
    int        h;
    int        pred;
    int        step;
    int        code_val;
    int        rec;
    bit        row_end;
    bit        last;
    code_res_t res;
    w = clamp_size(int'(cfg_width), MaxLine);
    h = clamp_size(int'(cfg_height), MaxRows);
    row_end = (line_col + 1 >= w);
    last = row_end && (line_row + 1 >= h);
    pred = (line_row == 0) ? int'(PredFirstRow) : int'(recon_line[line_col]);
    step = (cfg_mode == ModeNibble) ? NibbleStep : ByteStep;
    code_val = (int'(px) - pred + int'(DiffOffset)) / step;
    rec = code_val * step - int'(DiffOffset) + pred;
    if (rec < 0) rec = 0;
    else if (rec > PixelMax) rec = PixelMax;
    recon_line[line_col] = rec[PixelW-1:0];
    if (line_col >= store_fill) store_fill = line_col + 1;
    res = '0;
    res.recon = rec[PixelW-1:0];
    res.frame_last = last;
    if (cfg_mode == ModeByte) begin
      held_valid = 1'b0;
      held_code = '0;
      res.code_byte = code_val[PixelW-1:0];
      res.code_valid = 1'b1;
    end else if (held_valid) begin
      res.code_byte = {held_code, code_val[3:0]};
      res.code_valid = 1'b1;
      held_valid = 1'b0;
      held_code = '0;
    end else if (last) begin
      res.code_byte = {code_val[3:0], 4'h0};
      res.code_valid = 1'b1;
    end else begin
      held_code = code_val[3:0];
      held_valid = 1'b1;
    end
    if (row_end) begin
      line_col = 0;
      if (last) begin
        line_row = 0;
        held_valid = 1'b0;
        held_code = '0;
      end else begin
        line_row++;
      end
    end else begin
      line_col++;
    end
    return res;
  endfunction

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegLineWidth:   cfg_width = value[LineWidthW-1:0];
      RegFrameHeight: cfg_height = value[FrameHeightW-1:0];
      RegQuantMode:   cfg_mode = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PixelW-1:0] px, input bit typed, input code_res_t want);
    code_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel <= px;
    do @(posedge clk_i); while (!pix.ready);
    res = encode_pixel(px);
    pending_codes.push_back(typed ? want : res);
  endtask

  task automatic settle();
    pix.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : receiver_hold
    @(hold_go);
    hold_active <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  always @(posedge clk_i) begin : result_check
    code_res_t got;
    code_res_t want;
    if (!rst_ni) begin
      code.ready <= 1'b0;
    end else begin
      if (code.valid && code.ready) begin
        got = '{code.code_byte, code.code_valid, code.recon, code.frame_last};
        if (pending_codes.size() == 0) begin
          $display("%0t: unexpected transfer, byte %0d valid %0b recon %0d last %0b",
                   $time, got.code_byte, got.code_valid, got.recon, got.frame_last);
          mismatches++;
        end else begin
          want = pending_codes.pop_front();
          if (got.code_byte !== want.code_byte) begin
            $display("%0t: code_byte expected %0d, actual %0d",
                     $time, want.code_byte, got.code_byte);
            mismatches++;
          end
          if (got.code_valid !== want.code_valid) begin
            $display("%0t: code_valid expected %0b, actual %0b",
                     $time, want.code_valid, got.code_valid);
            mismatches++;
          end
          if (got.recon !== want.recon) begin
            $display("%0t: recon expected %0d, actual %0d", $time, want.recon, got.recon);
            mismatches++;
          end
          if (got.frame_last !== want.frame_last) begin
            $display("%0t: frame_last expected %0b, actual %0b",
                     $time, want.frame_last, got.frame_last);
            mismatches++;
          end
        end
      end
      if (hold_active) begin
        code.ready <= 1'b0;
      end else begin
        code.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((pix.valid && pix.ready) || (code.valid && code.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("** dpcm_vertical_uniform_encoder: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [PixelW-1:0] px;
    int                w;
    int                h;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    pix.valid  <= 1'b0;
    pix.pixel  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      case (DirTable[i].kind)
        RowCfg: begin
          settle();
          write_reg(DirTable[i].reg_idx, ApbDataW'(DirTable[i].value));
        end
        RowPixel: send_pixel(DirTable[i].px, 1'b0, NoRes);
        default:  send_pixel(DirTable[i].px, 1'b1, DirTable[i].want);
      endcase
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(7))
          0:       w = 0;
          1:       w = WidthFieldMax;
          2:       w = MaxLine;
          3:       w = $urandom_range(WidthFieldMax);
          default: w = $urandom_range(12, 1);
        endcase
        // Mid-frame, the row may only cover columns that already hold a reconstruction.
        if (line_row != 0 && clamp_size(w, MaxLine) > store_fill) w = store_fill;
        write_reg(RegLineWidth, ApbDataW'(($urandom() << LineWidthW) | w));
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(7))
          0:       h = 0;
          1:       h = RowsFieldMax;
          2:       h = MaxRows;
          3:       h = $urandom_range(RowsFieldMax);
          default: h = $urandom_range(6, 1);
        endcase
        write_reg(RegFrameHeight, ApbDataW'(($urandom() << FrameHeightW) | h));
      end
      if ($urandom_range(3) != 0) begin
        write_reg(RegQuantMode, ApbDataW'(($urandom() << 1) | $urandom_range(1)));
      end
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        if (ph == PressurePhase && k == 5) -> hold_go;
        if ($urandom_range(7) == 0) px = $urandom_range(1) ? PixelW'(PixelMax) : '0;
        else px = PixelW'($urandom_range(PixelMax));
        send_pixel(px, 1'b0, NoRes);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("** dpcm_vertical_uniform_encoder: PASSED **");
    end else begin
      $display("** dpcm_vertical_uniform_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dpcmv_pkg.sv
rtl/dpcmv_if.sv
rtl/dpcmv_cfg_regs.sv
rtl/dpcmv_line_store.sv
rtl/dpcmv_ctrl.sv
rtl/dpcmv_quant.sv
rtl/dpcm_vertical_uniform_encoder.sv
test/dpcm_vertical_uniform_encoder_test.sv
